@@ rtl/core/tws_pkg.sv @@
package tws_pkg;

  localparam int ADDR_W      = 4;
  localparam int VALUE_W     = 20;
  localparam int MHZ_W       = 13;
  localparam int READ_VALUE_W = 20;

  // Width used while a frame word is assembled, before it is cut to the frame length.
  localparam int BUILD_W     = 32;

  // f25 = MHz * 25 needs 18 bits for a 13-bit MHz value.
  localparam int F25_W       = 18;
  localparam int SYNTH_MULT  = 25;
  localparam int A_W         = 6;
  localparam int N_W         = F25_W - A_W;
  localparam int N_SHIFT     = 12;
  localparam int FLAG_BIT    = 4;

  localparam logic [ADDR_W-1:0] SYNTH_B_ADDR_RESET = 4'd1;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_FREQ  = 2'd3
  } action_t;

  typedef struct packed {
    logic start;
    logic is_read;
  } start_t;

endpackage

@@ rtl/core/tws_slot_if.sv @@
interface tws_slot_if;
  logic                         valid;
  logic                         ready;
  tws_pkg::action_t             action;
  logic [tws_pkg::ADDR_W-1:0]   reg_addr;
  logic [tws_pkg::VALUE_W-1:0]  write_value;
  logic [tws_pkg::MHZ_W-1:0]    freq_mhz;
  logic                         data_in;

  modport source (output valid, action, reg_addr, write_value, freq_mhz, data_in,
                  input ready);
  modport sink (input valid, action, reg_addr, write_value, freq_mhz, data_in,
                output ready);
endinterface

@@ rtl/core/tws_result_if.sv @@
interface tws_result_if;
  logic                              valid;
  logic                              ready;
  logic                              latch_enable_low;
  logic                              clock_pulse;
  logic                              data_out;
  logic                              drive_data;
  logic                              read_valid;
  logic [tws_pkg::READ_VALUE_W-1:0]  read_value;
  logic                              frame_end;
  logic                              busy_res;

  modport source (output valid, latch_enable_low, clock_pulse, data_out, drive_data,
                  read_valid, read_value, frame_end, busy_res,
                  input ready);
  modport sink (input valid, latch_enable_low, clock_pulse, data_out, drive_data,
                read_valid, read_value, frame_end, busy_res,
                output ready);
endinterface

@@ rtl/core/three_wire_synth_serial_master.sv @@
// Three-wire (latch, clock, data) serial master for a PLL synthesizer. Every accepted request
// is one bit slot and yields exactly one result; a write or frequency frame spans FRAME_BITS
// slots and a read frame HEADER_BITS + READ_DATA_BITS slots, sent least significant bit first.
// One request is taken per clock cycle while the receiver does not stall; each passes an input
// register and then the result register, where its result waits while the receiver stalls.
// The frame counter and shift register advance once per slot. Start requests that arrive
// while a frame runs are ignored.
// cfg_wdata sets the register address used by frequency frames (reset value 1).
module three_wire_synth_serial_master #(
  parameter int FRAME_BITS     = 25,
  parameter int READ_DATA_BITS = 20,
  parameter int HEADER_BITS    = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tws_pkg::ADDR_W-1:0]  cfg_wdata,
  tws_slot_if.sink                    slot,
  tws_result_if.source                result
);

  logic                         in_valid;
  tws_pkg::action_t             in_action;
  logic [tws_pkg::ADDR_W-1:0]   in_reg_addr;
  logic [tws_pkg::VALUE_W-1:0]  in_write_value;
  logic [tws_pkg::MHZ_W-1:0]    in_freq_mhz;
  logic                         in_data_in;
  logic [tws_pkg::ADDR_W-1:0]   synth_b_address;

  logic                         advance;
  tws_pkg::start_t              start_info;
  logic [FRAME_BITS-1:0]        word;

  // The held slot moves on whenever the result register is empty or being emptied.
  assign advance    = in_valid && (!result.valid || result.ready);
  assign slot.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      synth_b_address <= tws_pkg::SYNTH_B_ADDR_RESET;
    end else begin
      if (cfg_we) begin
        synth_b_address <= cfg_wdata;
      end
      if (slot.ready) begin
        in_valid <= slot.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot.valid && slot.ready) begin
      in_action      <= slot.action;
      in_reg_addr    <= slot.reg_addr;
      in_write_value <= slot.write_value;
      in_freq_mhz    <= slot.freq_mhz;
      in_data_in     <= slot.data_in;
    end
  end

  tws_word_build #(
    .FRAME_BITS  (FRAME_BITS),
    .HEADER_BITS (HEADER_BITS)
  ) u_word_build (
    .action          (in_action),
    .reg_addr        (in_reg_addr),
    .write_value     (in_write_value),
    .freq_mhz        (in_freq_mhz),
    .synth_b_address (synth_b_address),
    .start_info      (start_info),
    .word            (word)
  );

  tws_frame_core #(
    .FRAME_BITS     (FRAME_BITS),
    .READ_DATA_BITS (READ_DATA_BITS),
    .HEADER_BITS    (HEADER_BITS)
  ) u_frame_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .start_info (start_info),
    .word       (word),
    .data_in    (in_data_in),
    .result     (result)
  );

endmodule

@@ rtl/core/tws_word_build.sv @@
module tws_word_build #(
  parameter int FRAME_BITS  = 25,
  parameter int HEADER_BITS = 5
) (
  input  tws_pkg::action_t             action,
  input  logic [tws_pkg::ADDR_W-1:0]   reg_addr,
  input  logic [tws_pkg::VALUE_W-1:0]  write_value,
  input  logic [tws_pkg::MHZ_W-1:0]    freq_mhz,
  input  logic [tws_pkg::ADDR_W-1:0]   synth_b_address,
  output tws_pkg::start_t              start_info,
  output logic [FRAME_BITS-1:0]        word
);

  logic [tws_pkg::F25_W-1:0]   f25;
  logic [tws_pkg::A_W-1:0]     a_count;
  logic [tws_pkg::N_W-1:0]     n_count;
  logic [tws_pkg::BUILD_W-1:0] flag;
  logic [tws_pkg::BUILD_W-1:0] build;

  assign f25     = tws_pkg::F25_W'(freq_mhz) * tws_pkg::F25_W'(tws_pkg::SYNTH_MULT);
  assign a_count = f25[tws_pkg::A_W-1:0];
  assign n_count = f25[tws_pkg::F25_W-1:tws_pkg::A_W];
  assign flag    = tws_pkg::BUILD_W'(1) << tws_pkg::FLAG_BIT;

  always_comb begin
    unique case (action)
      tws_pkg::ACT_WRITE: begin
        build = tws_pkg::BUILD_W'(reg_addr) | flag
              | (tws_pkg::BUILD_W'(write_value) << HEADER_BITS);
      end
      tws_pkg::ACT_READ: begin
        build = tws_pkg::BUILD_W'(reg_addr)
              & ((tws_pkg::BUILD_W'(1) << HEADER_BITS) - tws_pkg::BUILD_W'(1));
      end
      tws_pkg::ACT_FREQ: begin
        build = tws_pkg::BUILD_W'(synth_b_address) | flag
              | (tws_pkg::BUILD_W'(a_count) << HEADER_BITS)
              | (tws_pkg::BUILD_W'(n_count) << tws_pkg::N_SHIFT);
      end
      default: begin
        build = '0;
      end
    endcase
  end

  assign word               = build[FRAME_BITS-1:0];
  assign start_info.start   = (action != tws_pkg::ACT_TICK);
  assign start_info.is_read = (action == tws_pkg::ACT_READ);

endmodule

@@ rtl/core/tws_frame_core.sv @@
module tws_frame_core #(
  parameter int FRAME_BITS     = 25,
  parameter int READ_DATA_BITS = 20,
  parameter int HEADER_BITS    = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  tws_pkg::start_t        start_info,
  input  logic [FRAME_BITS-1:0]  word,
  input  logic                   data_in,
  tws_result_if.source           result
);

  localparam int READ_LEN = HEADER_BITS + READ_DATA_BITS;
  localparam int LEN_MAX  = (READ_LEN > FRAME_BITS) ? READ_LEN : FRAME_BITS;
  localparam int CNT_W    = $clog2(LEN_MAX + 1);

  localparam logic [CNT_W-1:0] WRITE_LEN_C = CNT_W'(FRAME_BITS);
  localparam logic [CNT_W-1:0] READ_LEN_C  = CNT_W'(READ_LEN);
  localparam logic [CNT_W-1:0] HEADER_C    = CNT_W'(HEADER_BITS);

  logic [FRAME_BITS-1:0]     out_shift;
  logic [CNT_W-1:0]          slot_count;
  logic                      frame_active;
  logic                      frame_is_read;
  logic [READ_DATA_BITS-1:0] read_collect;

  logic                      start_now;
  logic                      active_eff;
  logic                      is_read_eff;
  logic [FRAME_BITS-1:0]     shift_eff;
  logic [CNT_W-1:0]          count_eff;
  logic [READ_DATA_BITS-1:0] collect_eff;
  logic [READ_DATA_BITS-1:0] collect_next;
  logic [CNT_W-1:0]          sample_idx;
  logic [CNT_W-1:0]          len;
  logic                      sampling;
  logic                      last;
  logic [READ_DATA_BITS+tws_pkg::READ_VALUE_W-1:0] collect_wide;

  // A start request is only honored between frames; otherwise the running frame advances.
  assign start_now   = !frame_active && start_info.start;
  assign active_eff  = frame_active || start_now;
  assign is_read_eff = start_now ? start_info.is_read : frame_is_read;
  assign shift_eff   = start_now ? word : out_shift;
  assign count_eff   = start_now ? '0 : slot_count;
  assign collect_eff = start_now ? '0 : read_collect;

  assign len        = is_read_eff ? READ_LEN_C : WRITE_LEN_C;
  assign sampling   = is_read_eff && (count_eff >= HEADER_C);
  assign last       = ({1'b0, count_eff} + (CNT_W + 1)'(1)) >= {1'b0, len};
  assign sample_idx = count_eff - HEADER_C;

  always_comb begin
    collect_next = collect_eff;
    for (int i = 0; i < READ_DATA_BITS; i++) begin
      if (sampling && data_in && (sample_idx == CNT_W'(i))) begin
        collect_next[i] = 1'b1;
      end
    end
  end

  assign collect_wide = (READ_DATA_BITS + tws_pkg::READ_VALUE_W)'(collect_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_shift     <= '0;
      slot_count    <= '0;
      frame_active  <= 1'b0;
      frame_is_read <= 1'b0;
      read_collect  <= '0;
      result.valid  <= 1'b0;
    end else begin
      if (advance) begin
        result.valid <= 1'b1;
        if (active_eff) begin
          out_shift     <= shift_eff >> 1;
          read_collect  <= collect_next;
          frame_active  <= !last;
          frame_is_read <= last ? 1'b0 : is_read_eff;
          slot_count    <= last ? '0 : count_eff + CNT_W'(1);
        end
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.latch_enable_low <= active_eff;
      result.clock_pulse      <= active_eff;
      result.data_out         <= active_eff && !sampling && shift_eff[0];
      result.drive_data       <= active_eff && !sampling;
      result.read_valid       <= active_eff && last && is_read_eff;
      result.read_value       <= (active_eff && last && is_read_eff)
                                 ? collect_wide[tws_pkg::READ_VALUE_W-1:0] : '0;
      result.frame_end        <= active_eff && last;
      result.busy_res         <= active_eff && !last;
    end
  end

endmodule

@@ bench/tb_three_wire_synth_serial_master.sv @@
`timescale 1ns / 1ps

module tb_three_wire_synth_serial_master;

  localparam int FRAME_LEN   = 25;
  localparam int HDR_LEN     = 5;
  localparam int RD_LEN      = 20;
  localparam int RANDOM_REQS = 925;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    tws_pkg::action_t             act;
    logic [tws_pkg::ADDR_W-1:0]   addr;
    logic [tws_pkg::VALUE_W-1:0]  value;
    logic [tws_pkg::MHZ_W-1:0]    mhz;
    logic                         din;
  } slot_req_t;

  typedef struct packed {
    logic                              latch_enable_low;
    logic                              clock_pulse;
    logic                              data_out;
    logic                              drive_data;
    logic                              read_valid;
    logic [tws_pkg::READ_VALUE_W-1:0]  read_value;
    logic                              frame_end;
    logic                              busy_res;
  } slot_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [tws_pkg::ADDR_W-1:0] cfg_wdata;

  tws_slot_if   slot_if ();
  tws_result_if res_if ();

  three_wire_synth_serial_master dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .slot      (slot_if),
    .result    (res_if)
  );

  // Shadow of the serializer state.
  logic [FRAME_LEN-1:0]        tx_shift;
  int unsigned                 slot_idx;
  bit                          in_frame;
  bit                          frame_rd;
  logic [RD_LEN-1:0]           rx_bits;
  logic [tws_pkg::ADDR_W-1:0]  freq_reg_addr;

  slot_res_t   slot_results_q[$];
  slot_req_t   seen_req;
  slot_res_t   want_res;
  int unsigned mismatches;
  int unsigned reqs_sent;
  int unsigned results_checked;
  int unsigned reads_done;
  int unsigned cycles;
  int unsigned hold_len;
  bit          tx_idle;
  bit          rx_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending.", cycles,
               slot_results_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic slot_res_t predict_slot(slot_req_t r);
    slot_res_t o;
    logic [tws_pkg::F25_W-1:0] f25;
    logic [31:0] word;
    int unsigned len;
    o = '0;
    if (!in_frame && r.act != tws_pkg::ACT_TICK) begin
      in_frame = 1'b1;
      slot_idx = 0;
      rx_bits  = '0;
      frame_rd = (r.act == tws_pkg::ACT_READ);
      case (r.act)
        tws_pkg::ACT_WRITE: word = {7'b0, r.value, 1'b1, r.addr};
        tws_pkg::ACT_READ:  word = {28'b0, r.addr};
        default: begin
          f25  = tws_pkg::F25_W'(r.mhz * tws_pkg::SYNTH_MULT);
          word = 32'(freq_reg_addr) | (32'd1 << tws_pkg::FLAG_BIT)
               | (32'(f25[tws_pkg::A_W-1:0]) << HDR_LEN)
               | (32'(f25[tws_pkg::F25_W-1:tws_pkg::A_W]) << tws_pkg::N_SHIFT);
        end
      endcase
      tx_shift = word[FRAME_LEN-1:0];
    end
    if (in_frame) begin
      len = frame_rd ? HDR_LEN + RD_LEN : FRAME_LEN;
      o.latch_enable_low = 1'b1;
      o.clock_pulse      = 1'b1;
      // Past the header of a read the pin is released and sampled instead.
      if (frame_rd && slot_idx >= HDR_LEN) begin
        if (r.din) rx_bits[5'(slot_idx - HDR_LEN)] = 1'b1;
      end else begin
        o.data_out   = tx_shift[0];
        o.drive_data = 1'b1;
      end
      tx_shift = tx_shift >> 1;
      if (slot_idx + 1 >= len) begin
        o.frame_end = 1'b1;
        if (frame_rd) begin
          o.read_valid = 1'b1;
          o.read_value = rx_bits;
        end
        in_frame = 1'b0;
        frame_rd = 1'b0;
        slot_idx = 0;
      end else begin
        o.busy_res = 1'b1;
        slot_idx++;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_frame      = 1'b0;
      frame_rd      = 1'b0;
      slot_idx      = 0;
      tx_shift      = '0;
      rx_bits       = '0;
      freq_reg_addr = tws_pkg::SYNTH_B_ADDR_RESET;
    end else begin
      if (cfg_we) freq_reg_addr = cfg_wdata;
      if (slot_if.valid && slot_if.ready) begin
        seen_req.act   = slot_if.action;
        seen_req.addr  = slot_if.reg_addr;
        seen_req.value = slot_if.write_value;
        seen_req.mhz   = slot_if.freq_mhz;
        seen_req.din   = slot_if.data_in;
        slot_results_q.push_back(predict_slot(seen_req));
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (slot_results_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want_res = slot_results_q.pop_front();
        check_field("latch_enable_low", 32'(want_res.latch_enable_low),
                    32'(res_if.latch_enable_low));
        check_field("clock_pulse", 32'(want_res.clock_pulse), 32'(res_if.clock_pulse));
        check_field("data_out", 32'(want_res.data_out), 32'(res_if.data_out));
        check_field("drive_data", 32'(want_res.drive_data), 32'(res_if.drive_data));
        check_field("read_valid", 32'(want_res.read_valid), 32'(res_if.read_valid));
        check_field("read_value", 32'(want_res.read_value), 32'(res_if.read_value));
        check_field("frame_end", 32'(want_res.frame_end), 32'(res_if.frame_end));
        check_field("busy_res", 32'(want_res.busy_res), 32'(res_if.busy_res));
        results_checked++;
        if (want_res.read_valid) reads_done++;
      end
    end
  end

  // Result side: random stalls per result, plus a long hold-off when one is requested.
  initial begin
    int unsigned rx_gap;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      rx_gap = rx_idle ? $urandom_range(0, 8) : 0;
      if (rx_gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  // Valid stays high after acceptance so back-to-back requests need no extra edge.
  task automatic send_slot(tws_pkg::action_t act, logic [tws_pkg::ADDR_W-1:0] addr,
                           logic [tws_pkg::VALUE_W-1:0] val,
                           logic [tws_pkg::MHZ_W-1:0] mhz, logic din);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      slot_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    slot_if.valid       <= 1'b1;
    slot_if.action      <= act;
    slot_if.reg_addr    <= addr;
    slot_if.write_value <= val;
    slot_if.freq_mhz    <= mhz;
    slot_if.data_in     <= din;
    @(posedge clk);
    while (!slot_if.ready) @(posedge clk);
    reqs_sent++;
  endtask

  // Start request followed by the remaining slots; sampled read bits come from rd_bits.
  // noise_pct is the share of follow-on slots that carry a start which must be ignored.
  task automatic run_frame(tws_pkg::action_t kind, logic [tws_pkg::ADDR_W-1:0] addr,
                           logic [tws_pkg::VALUE_W-1:0] val,
                           logic [tws_pkg::MHZ_W-1:0] mhz, logic [RD_LEN-1:0] rd_bits,
                           int unsigned noise_pct);
    tws_pkg::action_t act;
    logic din;
    send_slot(kind, addr, val, mhz, 1'($urandom_range(0, 1)));
    for (int i = 1; i < FRAME_LEN; i++) begin
      act = ($urandom_range(0, 99) < noise_pct)
            ? tws_pkg::action_t'(2'($urandom_range(1, 3))) : tws_pkg::ACT_TICK;
      din = (i >= HDR_LEN) ? rd_bits[5'(i - HDR_LEN)] : 1'($urandom_range(0, 1));
      send_slot(act, 4'($urandom_range(0, 15)), 20'($urandom), 13'($urandom), din);
    end
  endtask

  task automatic drain();
    slot_if.valid <= 1'b0;
    while (slot_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_freq_reg(logic [tws_pkg::ADDR_W-1:0] addr);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_idle_slots();
    send_slot(tws_pkg::ACT_TICK, '1, '1, '1, 1'b1);
    send_slot(tws_pkg::ACT_TICK, '0, '0, '0, 1'b0);
  endtask

  task automatic test_write_frame();
    run_frame(tws_pkg::ACT_WRITE, 4'hF, 20'hFFFFF, '0, '0, 0);
    run_frame(tws_pkg::ACT_WRITE, 4'h0, 20'h00000, '1, '1, 0);
  endtask

  task automatic test_read_frame();
    run_frame(tws_pkg::ACT_READ, 4'hF, '1, '1, 20'hFFFFF, 0);
    run_frame(tws_pkg::ACT_READ, 4'h0, '0, '0, 20'h00000, 0);
  endtask

  task automatic test_freq_frames();
    run_frame(tws_pkg::ACT_FREQ, '0, '0, 13'h1FFF, '0, 0);
    set_freq_reg(4'h0);
    run_frame(tws_pkg::ACT_FREQ, '1, '1, 13'd0, '1, 0);
    set_freq_reg(4'hF);
    run_frame(tws_pkg::ACT_FREQ, '0, '0, 13'd5800, '0, 0);
  endtask

  task automatic test_starts_while_busy();
    run_frame(tws_pkg::ACT_WRITE, 4'h5, 20'hA5A5A, '0, '0, 100);
    run_frame(tws_pkg::ACT_READ, 4'hA, '0, '0, 20'h5A5A5, 100);
  endtask

  // The receiver holds off long enough that the block fills and stops taking requests.
  task automatic test_output_stall();
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_len = 300;
    run_frame(tws_pkg::ACT_WRITE, 4'h3, 20'h12345, '0, '0, 10);
    run_frame(tws_pkg::ACT_READ, 4'hC, '0, '0, 20'($urandom), 10);
    run_frame(tws_pkg::ACT_FREQ, '0, '0, 13'($urandom), '0, 10);
    drain();
  endtask

  task automatic test_random_slots();
    int unsigned first;
    tws_pkg::action_t kind;
    first = reqs_sent;
    while (reqs_sent - first < RANDOM_REQS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 3) set_freq_reg(4'($urandom_range(0, 15)));
      if ($urandom_range(0, 99) < 15) begin
        send_slot(tws_pkg::ACT_TICK, 4'($urandom_range(0, 15)), 20'($urandom),
                  13'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        kind = tws_pkg::action_t'(2'($urandom_range(1, 3)));
        run_frame(kind, 4'($urandom_range(0, 15)), 20'($urandom), 13'($urandom),
                  20'($urandom), $urandom_range(0, 30));
      end
    end
    drain();
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    slot_if.valid       <= 1'b0;
    slot_if.action      <= tws_pkg::ACT_TICK;
    slot_if.reg_addr    <= '0;
    slot_if.write_value <= '0;
    slot_if.freq_mhz    <= '0;
    slot_if.data_in     <= 1'b0;
    mismatches      = 0;
    reqs_sent       = 0;
    results_checked = 0;
    reads_done      = 0;
    cycles          = 0;
    hold_len        = 0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_idle_slots();
    test_write_frame();
    test_read_frame();
    test_freq_frames();
    test_starts_while_busy();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_frame(tws_pkg::ACT_WRITE, 4'h9, 20'($urandom), '0, '0, 0);
    test_output_stall();
    set_freq_reg(tws_pkg::SYNTH_B_ADDR_RESET);
    test_random_slots();
    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d slot requests, checked %0d results, %0d read frames completed.",
             reqs_sent, results_checked, reads_done);
    $display("Write, read and frequency frames with ignored starts, stalls and address changes.");
    if (mismatches == 0 && slot_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
